// ===== design/dmbp_pkg.sv =====
package dmbp_pkg;

    localparam int PERIOD_W   = 16;
    localparam int PRESCALE_W = 17;
    localparam int SCALE_W    = 8;
    localparam int CMP_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int NUM_CH     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FWD_SCALE = 2'd2;

    localparam logic [PERIOD_W-1:0]   PERIOD_RST    = 16'd500;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RST  = 17'd72;
    localparam logic [SCALE_W-1:0]    FWD_SCALE_RST = 8'd100;

    localparam logic [CMP_W-1:0]  OFF_MARGIN = 17'd10;
    localparam logic [CMP_W-1:0]  CMP_RST    = {1'b0, PERIOD_RST} + OFF_MARGIN;
    localparam logic signed [17:0] NEG_FORCE = -18'sd300;
    localparam logic [SCALE_W-1:0] PCT       = 8'd100;

    // Reciprocal of 100 scaled by 2^30; exact for magnitudes below 2^23.
    localparam logic [23:0] DIV_MULT  = 24'd10737419;
    localparam int          DIV_SHIFT = 30;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic signed [1:0] DIR_DRIVE   = 2'sb01;
    localparam logic signed [1:0] DIR_BRAKE   = 2'sb00;
    localparam logic signed [1:0] DIR_REVERSE = 2'sb11;
    localparam logic signed [1:0] DIR_UNUSED  = 2'sb10;

    localparam logic [1:0] CH_LEFT_MOTOR  = 2'd0;
    localparam logic [1:0] CH_LEFT_BRAKE  = 2'd1;
    localparam logic [1:0] CH_RIGHT_MOTOR = 2'd2;
    localparam logic [1:0] CH_RIGHT_BRAKE = 2'd3;

    typedef enum logic [2:0] {
        KIND_TICK,
        KIND_DRIVE,
        KIND_BRAKE,
        KIND_REVERSE,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              side;
        logic signed [7:0] force_pct;
    } item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]   period;
        logic [PRESCALE_W-1:0] prescale;
        logic [SCALE_W-1:0]    fwd_scale;
    } cfg_t;

    typedef logic [NUM_CH-1:0] pins_t;

    // Signed division by 100, truncated toward zero.
    function automatic logic signed [17:0] div100(input logic signed [24:0] num);
        logic [23:0] mag;
        logic [47:0] prod;
        logic [17:0] q;
        mag  = num[24] ? 24'(-num) : num[23:0];
        prod = {24'd0, mag} * {24'd0, DIV_MULT};
        q    = prod[DIV_SHIFT +: 18];
        return num[24] ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== design/dual_motor_brake_pwm.sv =====
// PWM generator for two motors with a motor and a brake channel per side. A tick
// transaction advances the prescaler and period counter; a command transaction
// sets the compare values of one side. Every transaction returns one result with
// the four pin levels. Tick transactions are taken one per clock cycle while no
// command is in progress and each result is taken; their result passes through
// the input register and the two-entry queue, then the result register. A command
// steps the execution unit through a multiply, a reciprocal divide-by-100 and a
// clamp, then, when the drive scaling step is not skipped, a second multiply and
// divide, and then the write; the queue keeps accepting meanwhile until full. A
// result that is not taken stalls the execution unit until it is.
module dual_motor_brake_pwm (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [dmbp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dmbp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 opcode,
    input  logic                                 side,
    input  logic signed [1:0]                    direction,
    input  logic signed [7:0]                    force_percent,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 left_motor_on,
    output logic                                 left_brake_on,
    output logic                                 right_motor_on,
    output logic                                 right_brake_on
);
    import dmbp_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  front_valid;
    item_t front_item;
    logic  queue_full;
    logic  head_valid;
    item_t head_item;
    logic  head_pop;
    pins_t pins;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_PERIOD:    cfg_next.period    = cfg_data[PERIOD_W-1:0];
                CFG_PRESCALE:  cfg_next.prescale  = cfg_data[PRESCALE_W-1:0];
                CFG_FWD_SCALE: cfg_next.fwd_scale = cfg_data[SCALE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period    <= PERIOD_RST;
            cfg_reg.prescale  <= PRESCALE_RST;
            cfg_reg.fwd_scale <= FWD_SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dmbp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .side          (side),
        .direction     (direction),
        .force_percent (force_percent),
        .item_valid    (front_valid),
        .item          (front_item),
        .queue_full    (queue_full)
    );

    dmbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_item  (front_item),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (head_pop)
    );

    dmbp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .pins       (pins)
    );

    assign left_motor_on  = pins[CH_LEFT_MOTOR];
    assign left_brake_on  = pins[CH_LEFT_BRAKE];
    assign right_motor_on = pins[CH_RIGHT_MOTOR];
    assign right_brake_on = pins[CH_RIGHT_BRAKE];

endmodule

// ===== design/dmbp_front.sv =====
module dmbp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  opcode,
    input  logic                  side,
    input  logic signed [1:0]     direction,
    input  logic signed [7:0]     force_percent,
    output logic                  item_valid,
    output dmbp_pkg::item_t       item,
    input  logic                  queue_full
);
    import dmbp_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;
    item_t classified;
    logic  load, move;

    always_comb
    begin
        classified.side      = side;
        classified.force_pct = force_percent;
        if (opcode == OP_TICK)
        begin
            classified.kind = KIND_TICK;
        end
        else
        begin
            unique case (direction)
                DIR_DRIVE:   classified.kind = KIND_DRIVE;
                DIR_BRAKE:   classified.kind = KIND_BRAKE;
                DIR_REVERSE: classified.kind = KIND_REVERSE;
                DIR_UNUSED:  classified.kind = KIND_NOP;
            endcase
        end
    end

    assign full       = valid_reg && queue_full;
    assign load       = push && !full;
    assign move       = valid_reg && !queue_full;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (move)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= classified;
        end
    end

endmodule

// ===== design/dmbp_queue.sv =====
module dmbp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dmbp_pkg::item_t push_item,
    output logic            full,
    output logic            head_valid,
    output dmbp_pkg::item_t head_item,
    input  logic            pop
);
    import dmbp_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/dmbp_back.sv =====
module dmbp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  dmbp_pkg::cfg_t  cfg,
    input  logic            head_valid,
    input  dmbp_pkg::item_t head_item,
    output logic            head_pop,
    output logic            empty,
    input  logic            pop,
    output dmbp_pkg::pins_t pins
);
    import dmbp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV1  = 3'd1;
    localparam logic [2:0] S_CLAMP = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]              state_reg, state_next;
    item_t                   cmd_reg, cmd_next;
    logic signed [24:0]      prod_reg, prod_next;
    logic signed [17:0]      f_reg, f_next;
    logic [PRESCALE_W-1:0]   pcnt_reg, pcnt_next;
    logic [PERIOD_W-1:0]     cnt_reg, cnt_next;
    logic [CMP_W-1:0]        cmp_reg [NUM_CH];
    logic [CMP_W-1:0]        cmp_next [NUM_CH];
    pins_t                   pin_reg, pin_next;
    logic                    out_valid_reg, out_valid_next;
    pins_t                   out_pins_reg, out_pins_next;

    logic                    out_free;
    logic [PRESCALE_W-1:0]   top;
    logic [PRESCALE_W:0]     pc_inc;
    logic [PRESCALE_W-1:0]   tick_pcnt;
    logic [PERIOD_W-1:0]     tick_cnt;
    pins_t                   tick_pins;
    logic [CMP_W-1:0]        per_cmp;
    logic signed [17:0]      per_s;
    logic signed [17:0]      f_clamp;
    logic signed [17:0]      cmp_diff;
    logic [CMP_W-1:0]        cmp_val;
    logic [1:0]              motor_ch, brake_ch;

    assign out_free = !out_valid_reg || pop;
    assign head_pop = (state_reg == S_IDLE) && head_valid && out_free;
    assign empty    = !out_valid_reg;
    assign pins     = out_pins_reg;
    assign per_cmp  = {1'b0, cfg.period};
    assign per_s    = $signed({2'b0, cfg.period});
    assign motor_ch = {cmd_reg.side, 1'b0};
    assign brake_ch = {cmd_reg.side, 1'b1};

    // Prescaler, period counter and pin levels advance for one tick.
    always_comb
    begin
        top       = (cfg.prescale == '0) ? PRESCALE_W'(1) : cfg.prescale;
        pc_inc    = {1'b0, pcnt_reg} + (PRESCALE_W+1)'(1);
        tick_pcnt = pc_inc[PRESCALE_W-1:0];
        tick_cnt  = cnt_reg;
        tick_pins = pin_reg;
        if (pc_inc >= {1'b0, top})
        begin
            tick_pcnt = '0;
            if (cnt_reg >= cfg.period)
            begin
                tick_cnt  = '0;
                tick_pins = '0;
            end
            else
            begin
                tick_cnt = cnt_reg + PERIOD_W'(1);
            end
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (cmp_reg[i] == {1'b0, tick_cnt})
                begin
                    tick_pins[i] = (cmp_reg[i] < per_cmp);
                end
            end
        end
    end

    always_comb
    begin
        f_clamp = f_reg;
        if (f_clamp >= per_s)
        begin
            f_clamp = per_s;
        end
        if (f_clamp <= 18'sd0)
        begin
            f_clamp = NEG_FORCE;
        end
        cmp_diff = per_s - f_reg;
        cmp_val  = cmp_diff[CMP_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        prod_next      = prod_reg;
        f_next         = f_reg;
        pcnt_next      = pcnt_reg;
        cnt_next       = cnt_reg;
        cmp_next       = cmp_reg;
        pin_next       = pin_reg;
        out_valid_next = out_valid_reg && !pop;
        out_pins_next  = out_pins_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_pop)
                begin
                    unique case (head_item.kind)
                        KIND_TICK:
                        begin
                            pcnt_next      = tick_pcnt;
                            cnt_next       = tick_cnt;
                            pin_next       = tick_pins;
                            out_valid_next = 1'b1;
                            out_pins_next  = tick_pins;
                        end
                        KIND_NOP:
                        begin
                            out_valid_next = 1'b1;
                            out_pins_next  = pin_reg;
                        end
                        KIND_DRIVE, KIND_BRAKE, KIND_REVERSE:
                        begin
                            cmd_next   = head_item;
                            prod_next  = $signed({{17{head_item.force_pct[7]}},
                                                  head_item.force_pct})
                                       * $signed({9'd0, cfg.period});
                            state_next = S_DIV1;
                        end
                    endcase
                end
            end
            S_DIV1:
            begin
                f_next     = div100(prod_reg);
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                f_next = f_clamp;
                if (cmd_reg.kind == KIND_DRIVE && cfg.fwd_scale <= PCT)
                begin
                    state_next = S_MUL2;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_MUL2:
            begin
                prod_next  = $signed({{7{f_reg[17]}}, f_reg})
                           * $signed({17'd0, cfg.fwd_scale});
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                f_next     = div100(prod_reg);
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    if (cmd_reg.kind == KIND_DRIVE)
                    begin
                        cmp_next[brake_ch] = per_cmp + OFF_MARGIN;
                        pin_next[brake_ch] = 1'b0;
                        cmp_next[motor_ch] = cmp_val;
                    end
                    else if (cmd_reg.kind == KIND_REVERSE)
                    begin
                        cmp_next[motor_ch] = per_cmp + OFF_MARGIN;
                        pin_next[motor_ch] = 1'b0;
                        cmp_next[brake_ch] = cmp_val;
                    end
                    else
                    begin
                        cmp_next[motor_ch] = cmp_val;
                        cmp_next[brake_ch] = cmp_val;
                    end
                    out_valid_next = 1'b1;
                    out_pins_next  = pin_next;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pcnt_reg      <= '0;
            cnt_reg       <= '0;
            pin_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++)
            begin
                cmp_reg[i] <= CMP_RST;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pcnt_reg      <= pcnt_next;
            cnt_reg       <= cnt_next;
            pin_reg       <= pin_next;
            out_valid_reg <= out_valid_next;
            cmp_reg       <= cmp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        prod_reg     <= prod_next;
        f_reg        <= f_next;
        out_pins_reg <= out_pins_next;
    end

endmodule

// ===== design/dmbp_checker.sv =====
module dmbp_checker (
    input logic clk,
    input logic rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input logic left_motor_on,
    input logic left_brake_on,
    input logic right_motor_on,
    input logic right_brake_on
);

    // In the cycle after reset is seen, no transaction is pending on either side.
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queue not idle after reset");

    // The input side can only fill up right after it accepted a transaction.
    a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a preceding push");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result disappeared");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable({left_motor_on, left_brake_on,
                                    right_motor_on, right_brake_on}))
        else $error("waiting result changed");

endmodule

bind dual_motor_brake_pwm dmbp_checker u_checker (.*);
